[rtl/fac_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum box cull package
// Shared item types and constants for the frustum box cull block.
// ----------------------------------------------------------------------------
package fac_pkg;

    localparam int unsigned MatDepth = 16;
    localparam int unsigned QueueDepthDefault = 2;

    localparam logic CmdLoad = 1'b0;
    localparam logic CmdTest = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         matrix_index;
        logic signed [31:0] matrix_value;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
    } t_in_item;

    typedef struct packed {
        logic inside_res;
        logic was_test;
    } t_out_item;

endpackage
`default_nettype wire

[rtl/fac_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum box cull queue
// Short FIFO of items between the front and the back part.
// ----------------------------------------------------------------------------
module fac_queue #(
    parameter int unsigned DEPTH = fac_pkg::QueueDepthDefault
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  fac_pkg::t_in_item i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_empty,
    output fac_pkg::t_in_item o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    fac_pkg::t_in_item r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    ap_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underflow");
    ap_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count out of range");

endmodule
`default_nettype wire

[rtl/fac_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum box cull back end
// Holds the matrix and checks six planes with one shared dot-product unit.
// ----------------------------------------------------------------------------
module fac_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_empty,
    input  fac_pkg::t_in_item i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  wire               i_stall,
    output fac_pkg::t_out_item o_item
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SEL  = 5'b00010,
        S_MUL  = 5'b00100,
        S_ACC  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic signed [31:0] r_mat [fac_pkg::MatDepth];
    logic [2:0] r_pl;
    logic [1:0] r_ax;
    logic r_inside, r_nz;
    logic signed [32:0] r_na;
    logic signed [31:0] r_vb;
    logic signed [65:0] r_prod;
    logic signed [67:0] r_acc;
    fac_pkg::t_in_item r_box;
    logic r_ov;
    fac_pkg::t_out_item r_out;

    logic [1:0] k;
    logic       neg;
    logic signed [32:0] r3, rk, nsel;
    logic signed [31:0] vsel;

    assign k   = r_pl[2:1];
    assign neg = r_pl[0];

    always_comb begin
        r3 = 33'(r_mat[{r_ax, 2'd3}]);
        rk = 33'(r_mat[{r_ax, k}]);
        nsel = neg ? r3 - rk : r3 + rk;
        case (r_ax)
            2'd0: vsel = nsel >= 0 ? r_box.box_max_x : r_box.box_min_x;
            2'd1: vsel = nsel >= 0 ? r_box.box_max_y : r_box.box_min_y;
            2'd2: vsel = nsel >= 0 ? r_box.box_max_z : r_box.box_min_z;
            default: vsel = 32'sd65536;
        endcase
    end

    assign o_pop   = (r_state == S_IDLE) && !i_empty && (!r_ov || !i_stall);
    assign o_valid = r_ov;
    assign o_item  = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (o_pop && i_item.cmd == fac_pkg::CmdTest) n_state = S_SEL;
            S_SEL:   n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC: begin
                if (r_ax != 2'd3) n_state = S_SEL;
                else if (r_pl == 3'd5) n_state = S_OUT;
                else n_state = S_SEL;
            end
            S_OUT:   if (!r_ov || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            for (int i = 0; i < fac_pkg::MatDepth; i++) r_mat[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_box <= i_item;
                        r_pl <= '0;
                        r_ax <= '0;
                        r_acc <= '0;
                        r_nz <= 1'b0;
                        r_inside <= 1'b1;
                        if (i_item.cmd == fac_pkg::CmdLoad) begin
                            r_mat[i_item.matrix_index] <= i_item.matrix_value;
                            r_ov  <= 1'b1;
                            r_out <= '{inside_res: 1'b0, was_test: 1'b0};
                        end
                    end
                end
                S_SEL: begin
                    if (r_ax == 2'd3) begin
                        r_na <= neg ? 33'(r_mat[15]) - 33'(r_mat[{2'd3, k}])
                                    : 33'(r_mat[15]) + 33'(r_mat[{2'd3, k}]);
                        r_vb <= 32'sd65536;
                    end else begin
                        r_na <= nsel;
                        r_vb <= vsel;
                        if (nsel != 0) r_nz <= 1'b1;
                    end
                end
                S_MUL: r_prod <= r_na * r_vb;
                S_ACC: begin
                    if (r_ax == 2'd3) begin
                        if (r_nz && (r_acc + 68'(r_prod)) < 0) r_inside <= 1'b0;
                        r_acc <= '0;
                        r_nz  <= 1'b0;
                        r_ax  <= '0;
                        r_pl  <= r_pl + 3'd1;
                    end else begin
                        r_acc <= r_acc + 68'(r_prod);
                        r_ax  <= r_ax + 2'd1;
                    end
                end
                S_OUT: begin
                    if (!r_ov || !i_stall) begin
                        r_ov  <= 1'b1;
                        r_out <= '{inside_res: r_inside, was_test: 1'b1};
                    end
                end
                default: ;
            endcase
        end
    end

    ap_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE) else $error("pop outside idle");
    ap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_item)) else $error("result lost");
    ap_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEL |-> r_pl < 3'd6) else $error("plane index range");

endmodule
`default_nettype wire

[rtl/frustum_aabb_cull.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Frustum box cull top level
// Load items write the matrix; test items are checked against six planes.
// Throughput: one load item a cycle while the output is not stalled; a test holds
// the back part in the shared multiply-accumulate unit (six planes, four terms,
// three steps each: select, multiply, accumulate) before its result is given.
// A queue (two entries by default) lets input be taken while the back part works.
// Reset (synchronous, active low) clears the matrix, queue and result valid.
// ----------------------------------------------------------------------------
module frustum_aabb_cull #(
    parameter int unsigned QUEUE_DEPTH = fac_pkg::QueueDepthDefault
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  fac_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  wire                i_stall,
    output fac_pkg::t_out_item o_item
);
    logic full, empty, pop;
    fac_pkg::t_in_item q_item;

    assign o_stall = full;

    fac_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_valid && !full), .i_data(i_item), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_data(q_item)
    );

    fac_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(empty), .i_item(q_item), .o_pop(pop),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

endmodule
`default_nettype wire

[tb/frustum_aabb_cull_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frustum box cull testbench
// Drives matrix loads and box tests with random idling on both sides, predicts
// each verdict from a private copy of the matrix and checks results in order.
// ----------------------------------------------------------------------------
module frustum_aabb_cull_test;

    class cull_scoreboard;
        logic signed [31:0]  matrix [16];
        fac_pkg::t_out_item  pending [$];
        int                  errors;
        int                  tests_seen;
        int                  inside_seen;

        function new();
            foreach (matrix[i]) matrix[i] = '0;
            errors = 0;
            tests_seen = 0;
            inside_seen = 0;
        endfunction

        function bit plane_rejects(int k, bit minus, fac_pkg::t_in_item it);
            logic signed [32:0]  n [3];
            logic signed [32:0]  d;
            logic signed [32:0]  r3, rk;
            logic signed [31:0]  v;
            logic signed [127:0] sum;
            sum = '0;
            for (int a = 0; a < 3; a++) begin
                r3 = matrix[a * 4 + 3];
                rk = matrix[a * 4 + k];
                n[a] = minus ? r3 - rk : r3 + rk;
            end
            if (n[0] == 0 && n[1] == 0 && n[2] == 0) return 1'b0;
            r3 = matrix[15];
            rk = matrix[12 + k];
            d = minus ? r3 - rk : r3 + rk;
            for (int a = 0; a < 3; a++) begin
                case (a)
                    0: v = (n[a] >= 0) ? it.box_max_x : it.box_min_x;
                    1: v = (n[a] >= 0) ? it.box_max_y : it.box_min_y;
                    default: v = (n[a] >= 0) ? it.box_max_z : it.box_min_z;
                endcase
                sum = sum + 128'(n[a]) * 128'(v);
            end
            sum = sum + (128'(d) <<< 16);
            return sum < 0;
        endfunction

        function void note_input(fac_pkg::t_in_item it);
            fac_pkg::t_out_item r;
            if (it.cmd == fac_pkg::CmdLoad) begin
                matrix[it.matrix_index] = it.matrix_value;
                r = '0;
            end else begin
                r.was_test = 1'b1;
                r.inside_res = 1'b1;
                for (int k = 0; k < 3; k++)
                    if (plane_rejects(k, 0, it) || plane_rejects(k, 1, it))
                        r.inside_res = 1'b0;
                tests_seen++;
                if (r.inside_res) inside_seen++;
            end
            pending.push_back(r);
        endfunction

        function void check_result(fac_pkg::t_out_item got);
            fac_pkg::t_out_item want;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %b", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.inside_res !== want.inside_res) begin
                $display("%0t inside_res expected %b actual %b", $time,
                         want.inside_res, got.inside_res);
                errors++;
            end
            if (got.was_test !== want.was_test) begin
                $display("%0t was_test expected %b actual %b", $time,
                         want.was_test, got.was_test);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    fac_pkg::t_in_item  i_item = '0;
    logic               o_stall;
    logic               o_valid;
    fac_pkg::t_out_item o_item;

    cull_scoreboard sb = new();
    int  send_idle_pct = 8;
    int  recv_idle_pct = 78;
    bit  hold_off = 1'b0;

    always #6 i_clk = ~i_clk;

    frustum_aabb_cull DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) sb.note_input(i_item);
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_item);
    end

    always @(posedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'(int'($urandom_range(131072)) - 65536);
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // valid stays high after the last accept; the next call drives it again
    task automatic send(fac_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic load(int idx, logic signed [31:0] val);
        fac_pkg::t_in_item it;
        it = '0;
        it.cmd = fac_pkg::CmdLoad;
        it.matrix_index = idx[3:0];
        it.matrix_value = val;
        send(it);
    endtask

    task automatic test_box(logic signed [31:0] lo, logic signed [31:0] hi, bit rnd);
        fac_pkg::t_in_item it;
        it = '0;
        it.cmd = fac_pkg::CmdTest;
        it.matrix_index = 4'($urandom);
        it.matrix_value = $urandom;
        it.box_min_x = rnd ? rand_word() : lo;
        it.box_min_y = rnd ? rand_word() : lo;
        it.box_min_z = rnd ? rand_word() : lo;
        it.box_max_x = rnd ? rand_word() : hi;
        it.box_max_y = rnd ? rand_word() : hi;
        it.box_max_z = rnd ? rand_word() : hi;
        send(it);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0) load($urandom_range(15), rand_word());
            else test_box(0, 0, 1'b1);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // reset matrix: every box inside
        test_box(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
        // identity projection
        for (int i = 0; i < 16; i++) load(i, (i % 5 == 0) ? 32'sh0001_0000 : 0);
        test_box(-32'sh0000_8000, 32'sh0000_8000, 1'b0);
        test_box(32'sh0003_0000, 32'sh0004_0000, 1'b0);
        test_box(32'sh0001_0000, -32'sh0001_0000, 1'b0);
        test_box(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
        load(0, 32'sh7fff_ffff);
        load(3, 32'sh8000_0000);
        test_box(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
        random_phase(300);
        // hold the receiver off so the block fills and stalls its input
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                random_phase(20);
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        join
        send_idle_pct = 78;
        recv_idle_pct = 8;
        random_phase(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(300);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("covered %0d box tests (%0d inside) plus matrix loads, under",
                 sb.tests_seen, sb.inside_seen);
        $display("sender and receiver idling, a long receiver hold-off and full rate");
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule

[frustum_aabb_cull.f]
rtl/fac_pkg.sv
rtl/fac_queue.sv
rtl/fac_back.sv
rtl/frustum_aabb_cull.sv
tb/frustum_aabb_cull_test.sv
